>>> design/bta_pkg.sv
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types and codes of the boundary-tag next-fit allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bta_pkg;

  localparam int IDX_W    = 19;
  localparam int SIZE_W   = 17;
  localparam int CFG_W    = 14;
  localparam int OP_W     = 2;
  localparam int BYTES_W  = 16;
  localparam int ADDR_W   = 16;
  localparam int STATUS_W = 3;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

  localparam logic [STATUS_W-1:0] STS_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STS_FAIL       = 3'd1;
  localparam logic [STATUS_W-1:0] STS_FIRST_PREV = 3'd2;
  localparam logic [STATUS_W-1:0] STS_OVERRUN    = 3'd3;
  localparam logic [STATUS_W-1:0] STS_ADJ_FREE   = 3'd4;
  localparam logic [STATUS_W-1:0] STS_PREV_SEEN  = 3'd5;
  localparam logic [STATUS_W-1:0] STS_NEXT_PREV  = 3'd6;
  localparam logic [STATUS_W-1:0] STS_PREV_SIZE  = 3'd7;

  typedef struct packed {
    logic              used;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] prev;
  } hdr_t;

  typedef struct packed {
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    hdr_t             wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   address;
    logic [SIZE_W-1:0]   used_bytes;
    logic [SIZE_W-1:0]   free_bytes;
    logic [SIZE_W-1:0]   occupied_bytes;
    logic [SIZE_W-1:0]   unoccupied_bytes;
    logic [ADDR_W-1:0]   error_address;
  } res_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_A_RD, ST_A_EV, ST_A_S1, ST_A_S2, ST_A_S3,
    ST_F_RH, ST_F_RA, ST_F_RL, ST_F_RAA, ST_F_DEC, ST_F_W2,
    ST_C_R0, ST_C_0, ST_C_LOOP, ST_C_RA, ST_C_RL, ST_C_EV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> design/bta_in_if.sv
// ----------------------------------------------------------------------------
// bta_in_if
// Request channel: operation, request size and block address.
// ----------------------------------------------------------------------------
`default_nettype none

interface bta_in_if;
  import bta_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [BYTES_W-1:0] request_bytes;
  logic [ADDR_W-1:0]  block_address;

  modport source(output valid, operation, request_bytes, block_address, input ready);
  modport sink(input valid, operation, request_bytes, block_address, output ready);
endinterface

`default_nettype wire

>>> design/bta_out_if.sv
// ----------------------------------------------------------------------------
// bta_out_if
// Result channel: status, address, totals and fault location.
// ----------------------------------------------------------------------------
`default_nettype none

interface bta_out_if;
  import bta_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   address;
  logic [SIZE_W-1:0]   used_bytes;
  logic [SIZE_W-1:0]   free_bytes;
  logic [SIZE_W-1:0]   occupied_bytes;
  logic [SIZE_W-1:0]   unoccupied_bytes;
  logic [ADDR_W-1:0]   error_address;

  modport source(output valid, status, address, used_bytes, free_bytes, occupied_bytes,
                 unoccupied_bytes, error_address, input ready);
  modport sink(input valid, status, address, used_bytes, free_bytes, occupied_bytes,
               unoccupied_bytes, error_address, output ready);
endinterface

`default_nettype wire

>>> design/boundary_tag_next_fit_allocator.sv
// Allocate: each block header visited is read, then evaluated; a split then runs
// ST_A_S1 to ST_A_S3. Free: four header reads, then up to two write-backs.
// Check: the first header is read and tallied, then each further block passes
// through ST_C_LOOP, ST_C_RA, ST_C_RL and ST_C_EV. The result then goes into the
// output register; one item is worked at a time. Reset and each pool size write
// start a clearing pass over the header memory, during which no item is accepted.
// ----------------------------------------------------------------------------
// boundary_tag_next_fit_allocator
// Boundary-tag heap manager with next-fit search over a granule pool.
// ----------------------------------------------------------------------------
`default_nettype none

module boundary_tag_next_fit_allocator #(
  parameter int GRANULE_BYTES     = 8,
  parameter int POOL_MAX_GRANULES = 8192
) (
  input  logic                      clk,
  input  logic                      rst_n,
  bta_in_if.sink                    in_ch,
  bta_out_if.source                 out_ch,
  input  logic                      cfg_wr_en,
  input  logic [bta_pkg::CFG_W-1:0] cfg_wr_data
);
  import bta_pkg::*;

  mem_req_t         mem_req;
  hdr_t             mem_rdata;
  logic [IDX_W-1:0] mem_pool;
  res_t             res;
  logic             res_valid, res_ready;
  res_t             out_res_r;
  logic             out_valid_r;

  bta_ctrl #(
    .GRANULE_BYTES    (GRANULE_BYTES),
    .POOL_MAX_GRANULES(POOL_MAX_GRANULES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_op      (in_ch.operation),
    .in_bytes   (in_ch.request_bytes),
    .in_addr    (in_ch.block_address),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_req    (mem_req),
    .mem_pool   (mem_pool),
    .mem_rdata  (mem_rdata)
  );

  bta_hdr_mem #(
    .DEPTH(POOL_MAX_GRANULES)
  ) u_mem (
    .clk  (clk),
    .req  (mem_req),
    .pool (mem_pool),
    .rdata(mem_rdata)
  );

  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold the beat until taken
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_res_r <= res;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_res_r.status;
  assign out_ch.address          = out_res_r.address;
  assign out_ch.used_bytes       = out_res_r.used_bytes;
  assign out_ch.free_bytes       = out_res_r.free_bytes;
  assign out_ch.occupied_bytes   = out_res_r.occupied_bytes;
  assign out_ch.unoccupied_bytes = out_res_r.unoccupied_bytes;
  assign out_ch.error_address    = out_res_r.error_address;

endmodule

`default_nettype wire

>>> design/bta_hdr_mem.sv
// ----------------------------------------------------------------------------
// bta_hdr_mem
// Header store, one header per granule. Registered read; entries at or past
// the pool end read as zero and drop writes.
// ----------------------------------------------------------------------------
`default_nettype none

module bta_hdr_mem #(
  parameter int DEPTH = 8192
) (
  input  logic                    clk,
  input  bta_pkg::mem_req_t       req,
  input  logic [bta_pkg::IDX_W-1:0] pool,
  output bta_pkg::hdr_t           rdata
);
  import bta_pkg::*;

  localparam int AW = $clog2(DEPTH);

  hdr_t mem [DEPTH];
  hdr_t rd_r;
  logic rd_in_r;

  always_ff @(posedge clk) begin
    if (req.wr_en && (req.wr_addr < pool)) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_r    <= mem[req.rd_addr[AW-1:0]];
    rd_in_r <= req.rd_addr < pool;
  end

  assign rdata = rd_in_r ? rd_r : '0;

endmodule

`default_nettype wire

>>> design/bta_ctrl.sv
// ----------------------------------------------------------------------------
// bta_ctrl
// Sequencer: clears the pool, walks headers for allocate and check, and
// reads neighbors then writes back merged headers for free.
// ----------------------------------------------------------------------------
`default_nettype none

module bta_ctrl #(
  parameter int GRANULE_BYTES     = 8,
  parameter int POOL_MAX_GRANULES = 8192
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [bta_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bta_pkg::OP_W-1:0]    in_op,
  input  logic [bta_pkg::BYTES_W-1:0] in_bytes,
  input  logic [bta_pkg::ADDR_W-1:0]  in_addr,
  output logic                        res_valid,
  input  logic                        res_ready,
  output bta_pkg::res_t               res,
  output bta_pkg::mem_req_t           mem_req,
  output logic [bta_pkg::IDX_W-1:0]   mem_pool,
  input  bta_pkg::hdr_t               mem_rdata
);
  import bta_pkg::*;

  localparam logic [IDX_W-1:0] POOL_MAX   = IDX_W'(POOL_MAX_GRANULES);
  localparam logic [IDX_W-1:0] RESET_POOL = (POOL_MAX_GRANULES < 8192) ? POOL_MAX :
                                            IDX_W'(8192);
  localparam logic [IDX_W-1:0] ONE        = IDX_W'(1);

  typedef enum logic [2:0] {FK_CLR_H, FK_NEXT, FK_PREV, FK_PREV_END, FK_BOTH} fkind_t;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] pool_r, pool_nxt, search_r, search_nxt, clr_r, clr_nxt;
  logic [IDX_W-1:0] e_r, e_nxt, start_r, start_nxt, n_r, n_nxt, h_r, h_nxt;
  logic [IDX_W-1:0] after_r, after_nxt, last_r, last_nxt, aa_r, aa_nxt;
  logic [SIZE_W-1:0] req_r, req_nxt;
  hdr_t hd_r, hd_nxt, ad_r, ad_nxt, ld_r, ld_nxt;
  logic w2_en_r, w2_en_nxt;
  logic [IDX_W-1:0] w2_addr_r, w2_addr_nxt;
  hdr_t w2_data_r, w2_data_nxt;
  res_t res_r, res_nxt;

  hdr_t rd;
  logic [IDX_W-1:0] cfg_pool;
  logic [SIZE_W-1:0] a_req;
  logic f_bad;
  logic [IDX_W-1:0] f_h;
  logic a_fit, a_split, a_stop;
  logic [IDX_W-1:0] a_after, a_next, s_end, s_nw;
  logic c_e4, c_e5, c_e6, c_e7;
  logic [SIZE_W-1:0] acc_t, acc_pay, acc_tot;
  logic acc_used;
  fkind_t fk;
  logic [SIZE_W-1:0] mn_size, l1_size, l2_size;
  logic last_in, fr_w2_en;
  logic [IDX_W-1:0] fr_w2_addr;
  hdr_t fr_w2_data;

  function automatic logic [IDX_W-1:0] sat_pos(input logic [IDX_W-1:0] v,
                                               input logic [IDX_W-1:0] pool);
    return (v < pool) ? v : '0;
  endfunction

  function automatic logic [ADDR_W-1:0] to_bytes(input logic [IDX_W-1:0] v);
    return ADDR_W'(32'(v) * GRANULE_BYTES);
  endfunction

  assign rd        = mem_rdata;
  assign mem_pool  = pool_r;
  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;

  assign cfg_pool = (cfg_wr_data < CFG_W'(2)) ? IDX_W'(2) :
                    ((IDX_W'(cfg_wr_data) > POOL_MAX) ? POOL_MAX : IDX_W'(cfg_wr_data));

  assign a_req = SIZE_W'((32'(in_bytes) + GRANULE_BYTES - 1) / GRANULE_BYTES);
  assign f_h   = IDX_W'(32'(in_addr) / GRANULE_BYTES - 1);
  assign f_bad = ((32'(in_addr) % GRANULE_BYTES) != 0) || (32'(in_addr) < GRANULE_BYTES) ||
                 (f_h >= pool_r);

  assign a_fit   = !rd.used && (rd.size >= req_r);
  assign a_split = (rd.size - req_r) >= SIZE_W'(2);
  assign a_after = e_r + ONE + IDX_W'(rd.size);
  assign a_next  = (a_after >= pool_r) ? '0 : a_after;
  assign a_stop  = (a_next == start_r) || ((n_r + ONE) >= pool_r);
  assign s_end   = e_r + ONE + IDX_W'(hd_r.size);
  assign s_nw    = e_r + ONE + IDX_W'(req_r);

  assign c_e6 = (after_r != pool_r) && (ad_r.prev != hd_r.size);
  assign c_e7 = (hd_r.prev != '0) && (rd.size != hd_r.prev);
  assign c_e4 = !hd_r.used && !rd.used;
  assign c_e5 = rd.size != hd_r.prev;

  assign acc_t    = (state_r == ST_C_0) ? rd.size : hd_r.size;
  assign acc_used = (state_r == ST_C_0) ? rd.used : hd_r.used;
  assign acc_pay  = SIZE_W'(32'(acc_t) * GRANULE_BYTES);
  assign acc_tot  = SIZE_W'((32'(acc_t) + 1) * GRANULE_BYTES);

  // free: pick the merge case from the latched neighbors
  assign mn_size = SIZE_W'(18'(hd_r.size) + 18'(ad_r.size) + 18'd1);
  assign l1_size = SIZE_W'(18'(ld_r.size) + 18'(hd_r.size) + 18'd1);
  assign l2_size = SIZE_W'(19'(ld_r.size) + 19'(hd_r.size) + 19'(ad_r.size) + 19'd2);
  assign last_in = last_r < pool_r;

  always_comb begin
    if (hd_r.prev == '0) begin
      fk = ((after_r != pool_r) && !ad_r.used) ? FK_NEXT : FK_CLR_H;
    end else if (after_r != pool_r) begin
      priority if (ld_r.used && ad_r.used) fk = FK_CLR_H;
      else if (ld_r.used)                  fk = FK_NEXT;
      else if (ad_r.used)                  fk = FK_PREV;
      else                                 fk = FK_BOTH;
    end else begin
      fk = ld_r.used ? FK_CLR_H : FK_PREV_END;
    end
  end

  always_comb begin
    fr_w2_en   = 1'b0;
    fr_w2_addr = aa_r;
    fr_w2_data = hdr_t'{used: rd.used, size: rd.size, prev: mn_size};
    unique case (fk)
      FK_NEXT: begin
        fr_w2_en = aa_r != pool_r;
      end
      FK_PREV: begin
        fr_w2_en   = 1'b1;
        fr_w2_addr = after_r;
        fr_w2_data = hdr_t'{used: ad_r.used, size: ad_r.size,
                            prev: last_in ? l1_size : '0};
      end
      FK_BOTH: begin
        fr_w2_en   = aa_r != pool_r;
        fr_w2_data = hdr_t'{used: rd.used, size: rd.size, prev: last_in ? l2_size : '0};
      end
      FK_CLR_H, FK_PREV_END: begin
        fr_w2_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_r == pool_r - ONE) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            OP_ALLOC: state_nxt = (in_bytes == '0) ? ST_DONE : ST_A_RD;
            OP_FREE:  state_nxt = f_bad ? ST_DONE : ST_F_RH;
            OP_CHECK: state_nxt = ST_C_R0;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_A_RD:   state_nxt = ST_A_EV;
      ST_A_EV: begin
        if (a_fit)       state_nxt = a_split ? ST_A_S1 : ST_DONE;
        else if (a_stop) state_nxt = ST_DONE;
        else             state_nxt = ST_A_RD;
      end
      ST_A_S1:   state_nxt = ST_A_S2;
      ST_A_S2:   state_nxt = ST_A_S3;
      ST_A_S3:   state_nxt = ST_DONE;
      ST_F_RH:   state_nxt = ST_F_RA;
      ST_F_RA:   state_nxt = ST_F_RL;
      ST_F_RL:   state_nxt = ST_F_RAA;
      ST_F_RAA:  state_nxt = ST_F_DEC;
      ST_F_DEC:  state_nxt = fr_w2_en ? ST_F_W2 : ST_DONE;
      ST_F_W2:   state_nxt = ST_DONE;
      ST_C_R0:   state_nxt = ST_C_0;
      ST_C_0:    state_nxt = (rd.prev != '0) ? ST_DONE : ST_C_LOOP;
      ST_C_LOOP: state_nxt = (e_r >= pool_r) ? ST_DONE : ST_C_RA;
      ST_C_RA:   state_nxt = ST_C_RL;
      ST_C_RL:   state_nxt = ST_C_EV;
      ST_C_EV:   state_nxt = (c_e6 || c_e7 || c_e4 || c_e5) ? ST_DONE : ST_C_LOOP;
      ST_DONE:   if (res_ready) state_nxt = ST_IDLE;
    endcase
    if (cfg_wr_en) state_nxt = ST_CLEAR;
  end

  always_comb begin
    pool_nxt    = pool_r;
    search_nxt  = search_r;
    clr_nxt     = clr_r;
    e_nxt       = e_r;
    start_nxt   = start_r;
    n_nxt       = n_r;
    h_nxt       = h_r;
    after_nxt   = after_r;
    last_nxt    = last_r;
    aa_nxt      = aa_r;
    req_nxt     = req_r;
    hd_nxt      = hd_r;
    ad_nxt      = ad_r;
    ld_nxt      = ld_r;
    w2_en_nxt   = w2_en_r;
    w2_addr_nxt = w2_addr_r;
    w2_data_nxt = w2_data_r;
    res_nxt     = res_r;
    mem_req         = '0;
    mem_req.rd_addr = e_r;

    unique case (state_r)
      ST_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = clr_r;
        mem_req.wr_data = (clr_r == '0) ?
                          hdr_t'{used: 1'b0, size: SIZE_W'(pool_r - ONE), prev: '0} : '0;
        clr_nxt = clr_r + ONE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          res_nxt = '0;
          unique case (in_op)
            OP_ALLOC: begin
              if (in_bytes == '0) res_nxt.status = STS_FAIL;
              req_nxt   = a_req;
              e_nxt     = search_r;
              start_nxt = search_r;
              n_nxt     = '0;
            end
            OP_FREE:  h_nxt = f_h;
            OP_CHECK: e_nxt = '0;
            default:  res_nxt = '0;
          endcase
        end
      end
      ST_A_RD: mem_req.rd_addr = e_r;
      ST_A_EV: begin
        if (a_fit) begin
          hd_nxt          = rd;
          res_nxt.address = to_bytes(e_r + ONE);
          if (!a_split) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = e_r;
            mem_req.wr_data = hdr_t'{used: 1'b1, size: rd.size, prev: rd.prev};
            search_nxt      = sat_pos(a_after, pool_r);
          end
        end else begin
          e_nxt = a_next;
          n_nxt = n_r + ONE;
          if (a_stop) res_nxt.status = STS_FAIL;
        end
      end
      ST_A_S1: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = s_nw;
        mem_req.wr_data = hdr_t'{used: 1'b0, size: hd_r.size - req_r - SIZE_W'(1),
                                 prev: req_r};
      end
      ST_A_S2: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = e_r;
        mem_req.wr_data = hdr_t'{used: 1'b1, size: req_r, prev: hd_r.prev};
        mem_req.rd_addr = s_end;
      end
      ST_A_S3: begin
        mem_req.wr_en   = s_end != pool_r;
        mem_req.wr_addr = s_end;
        mem_req.wr_data = hdr_t'{used: rd.used, size: rd.size,
                                 prev: hd_r.size - req_r - SIZE_W'(1)};
        search_nxt      = sat_pos(s_nw, pool_r);
      end
      ST_F_RH: mem_req.rd_addr = h_r;
      ST_F_RA: begin
        hd_nxt          = rd;
        after_nxt       = h_r + ONE + IDX_W'(rd.size);
        mem_req.rd_addr = after_nxt;
      end
      ST_F_RL: begin
        ad_nxt          = rd;
        last_nxt        = h_r - ONE - IDX_W'(hd_r.prev);
        aa_nxt          = after_r + ONE + IDX_W'(rd.size);
        mem_req.rd_addr = last_nxt;
      end
      ST_F_RAA: begin
        ld_nxt          = rd;
        mem_req.rd_addr = aa_r;
      end
      ST_F_DEC: begin
        mem_req.wr_en = 1'b1;
        w2_en_nxt     = fr_w2_en;
        w2_addr_nxt   = fr_w2_addr;
        w2_data_nxt   = fr_w2_data;
        unique case (fk)
          FK_CLR_H: begin
            mem_req.wr_addr = h_r;
            mem_req.wr_data = hdr_t'{used: 1'b0, size: hd_r.size, prev: hd_r.prev};
          end
          FK_NEXT: begin
            mem_req.wr_addr = h_r;
            mem_req.wr_data = hdr_t'{used: 1'b0, size: mn_size, prev: hd_r.prev};
            if (after_r == search_r) search_nxt = sat_pos(h_r, pool_r);
          end
          FK_PREV, FK_PREV_END: begin
            mem_req.wr_addr = last_r;
            mem_req.wr_data = hdr_t'{used: ld_r.used, size: l1_size, prev: ld_r.prev};
            if (h_r == search_r) search_nxt = sat_pos(last_r, pool_r);
          end
          FK_BOTH: begin
            mem_req.wr_addr = last_r;
            mem_req.wr_data = hdr_t'{used: ld_r.used, size: l2_size, prev: ld_r.prev};
            if ((h_r == search_r) || (after_r == search_r)) begin
              search_nxt = sat_pos(last_r, pool_r);
            end
          end
        endcase
      end
      ST_F_W2: begin
        mem_req.wr_en   = w2_en_r;
        mem_req.wr_addr = w2_addr_r;
        mem_req.wr_data = w2_data_r;
      end
      ST_C_R0: mem_req.rd_addr = '0;
      ST_C_0: begin
        if (acc_used) begin
          res_nxt.used_bytes     = res_r.used_bytes + acc_pay;
          res_nxt.occupied_bytes = res_r.occupied_bytes + acc_tot;
        end else begin
          res_nxt.free_bytes       = res_r.free_bytes + acc_pay;
          res_nxt.unoccupied_bytes = res_r.unoccupied_bytes + acc_tot;
        end
        if (rd.prev != '0) res_nxt.status = STS_FIRST_PREV;
        e_nxt    = ONE + IDX_W'(rd.size);
        last_nxt = '0;
      end
      ST_C_LOOP: begin
        mem_req.rd_addr = e_r;
        if (e_r > pool_r) begin
          res_nxt.status        = STS_OVERRUN;
          res_nxt.error_address = to_bytes(e_r);
        end
      end
      ST_C_RA: begin
        hd_nxt    = rd;
        after_nxt = e_r + ONE + IDX_W'(rd.size);
        if (rd.prev != '0) last_nxt = e_r - ONE - IDX_W'(rd.prev);
        mem_req.rd_addr = after_nxt;
      end
      ST_C_RL: begin
        ad_nxt          = rd;
        mem_req.rd_addr = last_r;
      end
      ST_C_EV: begin
        priority if (c_e6) begin
          res_nxt.status        = STS_NEXT_PREV;
          res_nxt.error_address = to_bytes(e_r);
        end else if (c_e7) begin
          res_nxt.status        = STS_PREV_SIZE;
          res_nxt.error_address = to_bytes(e_r);
        end else if (c_e4) begin
          res_nxt.status        = STS_ADJ_FREE;
          res_nxt.error_address = to_bytes(last_r);
        end else begin
          if (acc_used) begin
            res_nxt.used_bytes     = res_r.used_bytes + acc_pay;
            res_nxt.occupied_bytes = res_r.occupied_bytes + acc_tot;
          end else begin
            res_nxt.free_bytes       = res_r.free_bytes + acc_pay;
            res_nxt.unoccupied_bytes = res_r.unoccupied_bytes + acc_tot;
          end
          if (c_e5) begin
            res_nxt.status        = STS_PREV_SEEN;
            res_nxt.error_address = to_bytes(last_r);
          end else begin
            last_nxt = e_r;
            e_nxt    = after_r;
          end
        end
      end
      ST_DONE: res_nxt = res_r;
    endcase

    if (cfg_wr_en) begin
      pool_nxt   = cfg_pool;
      search_nxt = '0;
      clr_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      pool_r   <= RESET_POOL;
      search_r <= '0;
      clr_r    <= '0;
      w2_en_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pool_r   <= pool_nxt;
      search_r <= search_nxt;
      clr_r    <= clr_nxt;
      w2_en_r  <= w2_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r       <= e_nxt;
    start_r   <= start_nxt;
    n_r       <= n_nxt;
    h_r       <= h_nxt;
    after_r   <= after_nxt;
    last_r    <= last_nxt;
    aa_r      <= aa_nxt;
    req_r     <= req_nxt;
    hd_r      <= hd_nxt;
    ad_r      <= ad_nxt;
    ld_r      <= ld_nxt;
    w2_addr_r <= w2_addr_nxt;
    w2_data_r <= w2_data_nxt;
    res_r     <= res_nxt;
  end

endmodule

`default_nettype wire
